[rtl/core/sensor_velocity_scale_curve_assert.svh]
// Assertion helpers for the velocity scaler; clocked on clk, quiet during rst.
`ifndef SENSOR_VELOCITY_SCALE_CURVE_ASSERT_SVH
`define SENSOR_VELOCITY_SCALE_CURVE_ASSERT_SVH

// Same-cycle implication
`define SVSC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("svsc assertion failed");

// Next-cycle implication
`define SVSC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("svsc assertion failed");

`endif

[rtl/core/svsc_pkg.sv]
package svsc_pkg;

  localparam int SAMPLE_W = 10;
  localparam int VEL_W    = 7;
  localparam int NUM_W    = 2 * SAMPLE_W;
  localparam int QUOT_W   = SAMPLE_W;

  localparam logic [SAMPLE_W-1:0] FULL_SCALE = 10'd1023;
  localparam logic [SAMPLE_W-1:0] SPAN       = 10'd1022;
  localparam logic [VEL_W-1:0]    VEL_MAX    = 7'd127;

  // Divider pipeline shape
  localparam int DIV_BITS_PER_STAGE = 2;
  localparam int DIV_STAGES         = QUOT_W / DIV_BITS_PER_STAGE;

  // Register indexes
  localparam logic [1:0] REG_LOW_THR  = 2'd0;
  localparam logic [1:0] REG_HIGH_THR = 2'd1;
  localparam logic [1:0] REG_MODE     = 2'd2;

  // Curve modes
  localparam logic [2:0] MODE_LINEAR = 3'd0;
  localparam logic [2:0] MODE_EXP2   = 3'd1;
  localparam logic [2:0] MODE_EXP4   = 3'd2;
  localparam logic [2:0] MODE_LOG2   = 3'd3;
  localparam logic [2:0] MODE_LOG4   = 3'd4;

  // Scaling class of a sample
  localparam logic [1:0] KIND_ZERO = 2'd0;
  localparam logic [1:0] KIND_MID  = 2'd1;
  localparam logic [1:0] KIND_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]          kind;
    logic [2:0]          mode;
    logic [NUM_W-1:0]    rem;
    logic [SAMPLE_W-1:0] den;
    logic [QUOT_W-1:0]   quot;
  } work_t;

  typedef logic [3:0][1023:0][VEL_W-1:0] curve_tab_t;

  localparam logic [63:0] Q_ONE = 64'd1 << 48;

  // One step of b^k in Q48, rounded half up; b chosen by curve
  function automatic logic [63:0] power_step(input logic [63:0] p, input logic [1:0] c);
    logic [63:0] r;
    case (c)
      2'd0:    r = (p * 64'd501 + 64'd250) / 64'd500;
      2'd1:    r = (p * 64'd251 + 64'd125) / 64'd250;
      2'd2:    r = (p * 64'd499 + 64'd250) / 64'd500;
      default: r = (p * 64'd249 + 64'd125) / 64'd250;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] abs_diff(input logic [63:0] a, input logic [63:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  // Build all four curve tables at elaboration
  function automatic curve_tab_t build_curves();
    curve_tab_t  tab;
    logic [63:0] p;
    logic [63:0] dfull;
    logic [63:0] d;
    logic [63:0] q;
    logic [63:0] num;
    logic [63:0] den2;
    logic [1:0]  cc;
    tab = '0;
    for (int c = 0; c < 4; c++) begin
      cc = 2'(c);
      p = Q_ONE;
      for (int k = 0; k < 1022; k++) begin
        p = power_step(p, cc);
      end
      dfull = abs_diff(p, Q_ONE);
      den2  = dfull << 1;
      p = Q_ONE;
      for (int k = 1; k < 1024; k++) begin
        d   = abs_diff(p, Q_ONE);
        num = 64'd252 * d + dfull;
        // Long division by twice the full deviation; the quotient fits in eight bits
        q = '0;
        for (int i = 7; i >= 0; i--) begin
          if (num >= (den2 << i)) begin
            num = num - (den2 << i);
            q   = q | (64'd1 << i);
          end
        end
        if (q > 64'd126) begin
          q = 64'd126;
        end
        tab[cc][10'(k)] = VEL_W'(q + 64'd1);
        p = power_step(p, cc);
      end
    end
    return tab;
  endfunction

  localparam curve_tab_t CURVE_ROM = build_curves();

endpackage

[rtl/core/svsc_front.sv]
module svsc_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [svsc_pkg::SAMPLE_W-1:0] low_thr,
  input  logic [svsc_pkg::SAMPLE_W-1:0] high_thr,
  input  logic [2:0]                    mode,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [svsc_pkg::SAMPLE_W-1:0] sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output svsc_pkg::work_t               out_work
);

  svsc_pkg::work_t               work_next;
  logic [svsc_pkg::SAMPLE_W-1:0] diff;
  logic [svsc_pkg::SAMPLE_W-1:0] range_w;

  assign in_ready = !out_valid || out_ready;

  // Classify the sample and form the dividend and divisor
  always_comb begin
    diff    = sample - low_thr;
    range_w = high_thr - low_thr;
    if (sample == '0 || sample < low_thr) begin
      work_next.kind = svsc_pkg::KIND_ZERO;
    end else if (sample >= high_thr) begin
      work_next.kind = svsc_pkg::KIND_FULL;
    end else begin
      work_next.kind = svsc_pkg::KIND_MID;
    end
    work_next.mode = mode;
    work_next.rem  = svsc_pkg::NUM_W'({10'd0, diff} * {10'd0, svsc_pkg::SPAN});
    work_next.den  = range_w;
    work_next.quot = '0;
  end

  // Load when the stage is empty or moving
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_work <= work_next;
    end
  end

endmodule

[rtl/core/svsc_div_stage.sv]
module svsc_div_stage #(
  parameter int STAGE = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  svsc_pkg::work_t in_work,
  output logic            out_valid,
  input  logic            out_ready,
  output svsc_pkg::work_t out_work
);

  svsc_pkg::work_t            work_next;
  logic [svsc_pkg::NUM_W-1:0] dsh;
  int                         pos;

  assign in_ready = !out_valid || out_ready;

  // Resolve a few quotient bits, most significant first
  always_comb begin
    work_next = in_work;
    for (int j = 0; j < svsc_pkg::DIV_BITS_PER_STAGE; j++) begin
      pos = svsc_pkg::QUOT_W - 1 - (STAGE * svsc_pkg::DIV_BITS_PER_STAGE + j);
      dsh = svsc_pkg::NUM_W'({{(svsc_pkg::NUM_W - svsc_pkg::SAMPLE_W){1'b0}}, work_next.den}
                             << pos);
      if (work_next.rem >= dsh) begin
        work_next.rem  = work_next.rem - dsh;
        work_next.quot = work_next.quot | (svsc_pkg::QUOT_W'(1) << pos);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_work <= work_next;
    end
  end

endmodule

[rtl/core/svsc_curve.sv]
module svsc_curve (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  svsc_pkg::work_t            in_work,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [svsc_pkg::VEL_W-1:0] velocity
);

  logic [svsc_pkg::SAMPLE_W-1:0] s;
  logic [svsc_pkg::SAMPLE_W-1:0] s_m1;
  logic [svsc_pkg::VEL_W:0]      lin;
  logic [2:0]                    mode_m1;
  logic [svsc_pkg::VEL_W-1:0]    vel_next;

  assign in_ready = !out_valid || out_ready;

  // Rebuild the scaled value from its class and quotient
  always_comb begin
    case (in_work.kind)
      svsc_pkg::KIND_ZERO: s = '0;
      svsc_pkg::KIND_FULL: s = svsc_pkg::FULL_SCALE;
      svsc_pkg::KIND_MID:  s = in_work.quot + 10'd1;
      default:             s = '0;
    endcase
  end

  // Map to a velocity: drop three bits, or look up the curve table
  always_comb begin
    s_m1    = s - 10'd1;
    lin     = {1'b0, s_m1[9:3]} + 8'd1;
    mode_m1 = in_work.mode - 3'd1;
    if (s == '0) begin
      vel_next = '0;
    end else begin
      case (in_work.mode)
        svsc_pkg::MODE_LINEAR: begin
          vel_next = lin[svsc_pkg::VEL_W] ? svsc_pkg::VEL_MAX : lin[svsc_pkg::VEL_W-1:0];
        end
        svsc_pkg::MODE_EXP2,
        svsc_pkg::MODE_EXP4,
        svsc_pkg::MODE_LOG2,
        svsc_pkg::MODE_LOG4: vel_next = svsc_pkg::CURVE_ROM[mode_m1[1:0]][s];
        default:             vel_next = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      velocity <= vel_next;
    end
  end

endmodule

[rtl/core/sensor_velocity_scale_curve.sv]
// Channel   Direction  Fields
// s_*       in         s_tdata[9:0] sample
// m_*       out        m_tdata[6:0] velocity
// cfg_*     in         index 0 low_threshold, 1 high_threshold, 2 curve_mode
//
// One item per cycle unless the output stalls; each item passes through
// seven register stages: classify, five divider stages of two quotient bits, curve.
// The curve table is read in the last stage.
// Reset clears all stage valid bits and loads the register defaults.
// Each stage holds under stall and refills bubbles, so input keeps flowing
// while a result waits at the output until all seven stages hold an item.
`include "sensor_velocity_scale_curve_assert.svh"

module sensor_velocity_scale_curve (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [9:0] sample, rest zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [6:0] velocity, [7] zero
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_wdata
);

  logic [svsc_pkg::SAMPLE_W-1:0] low_thr;
  logic [svsc_pkg::SAMPLE_W-1:0] high_thr;
  logic [2:0]                    curve_mode;
  logic [svsc_pkg::VEL_W-1:0]    velocity;

  svsc_pkg::work_t dw [0:svsc_pkg::DIV_STAGES];
  logic            dv [0:svsc_pkg::DIV_STAGES];
  logic            dr [0:svsc_pkg::DIV_STAGES];

  svsc_pkg::work_t tail_work;
  logic            tail_mid;
  logic            tail_zero;

  // Write configuration registers; ignore unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      low_thr    <= '0;
      high_thr   <= svsc_pkg::FULL_SCALE;
      curve_mode <= svsc_pkg::MODE_LINEAR;
    end else if (cfg_we) begin
      case (cfg_index)
        svsc_pkg::REG_LOW_THR:  low_thr    <= cfg_wdata;
        svsc_pkg::REG_HIGH_THR: high_thr   <= cfg_wdata;
        svsc_pkg::REG_MODE:     curve_mode <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  svsc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .low_thr   (low_thr),
    .high_thr  (high_thr),
    .mode      (curve_mode),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .sample    (s_tdata[9:0]),
    .out_valid (dv[0]),
    .out_ready (dr[0]),
    .out_work  (dw[0])
  );

  // Divider chain
  for (genvar g = 0; g < svsc_pkg::DIV_STAGES; g++) begin : g_div
    svsc_div_stage #(.STAGE(g)) u_div (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (dv[g]),
      .in_ready  (dr[g]),
      .in_work   (dw[g]),
      .out_valid (dv[g+1]),
      .out_ready (dr[g+1]),
      .out_work  (dw[g+1])
    );
  end

  svsc_curve u_curve (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dv[svsc_pkg::DIV_STAGES]),
    .in_ready  (dr[svsc_pkg::DIV_STAGES]),
    .in_work   (dw[svsc_pkg::DIV_STAGES]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .velocity  (velocity)
  );

  assign m_tdata = {1'b0, velocity};

  // Last divider stage as seen by the checks
  assign tail_work = dw[svsc_pkg::DIV_STAGES];
  assign tail_mid  = dv[svsc_pkg::DIV_STAGES] && tail_work.kind == svsc_pkg::KIND_MID;
  assign tail_zero = dv[svsc_pkg::DIV_STAGES] && dr[svsc_pkg::DIV_STAGES] &&
                     tail_work.kind == svsc_pkg::KIND_ZERO;

  // Checks
  `SVSC_ASSERT_IMP(a_quot_in_span, tail_mid, tail_work.quot < svsc_pkg::SPAN)
  `SVSC_ASSERT_NXT(a_zero_gives_zero, tail_zero, m_tvalid && m_tdata[6:0] == 7'd0)
  `SVSC_ASSERT_NXT(a_accept_loads, s_tvalid && s_tready, dv[0])

endmodule
